@@ sv/abst_pkg.sv @@
// ----------------------------------------------------------------------------
// abst_pkg
// Shared types, sizes and helpers for the array binary search tree.
// ----------------------------------------------------------------------------
`default_nettype none

package abst_pkg;

    localparam int SLOTS    = 1024;
    localparam int KEY_BITS = 32;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int IDX_W    = SLOT_W + 1;
    localparam int WORD_W   = KEY_BITS + 1;

    typedef logic signed [KEY_BITS-1:0] key_t;
    typedef logic [IDX_W-1:0]           idx_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WCHK,
        S_RCHK,
        S_LCHK,
        S_DESC,
        S_FINISH
    } state_t;

    function automatic key_t key_of(input logic [31:0] raw);
        return KEY_BITS'($signed(raw));
    endfunction

    function automatic idx_t child_lo(input idx_t s);
        return {s[SLOT_W-1:0], 1'b0};
    endfunction

    function automatic idx_t child_hi(input idx_t s);
        return {s[SLOT_W-1:0], 1'b1};
    endfunction

endpackage

`default_nettype wire

@@ sv/abst_ram.sv @@
// ----------------------------------------------------------------------------
// abst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module abst_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 33,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/array_binary_search_tree.sv @@
// ----------------------------------------------------------------------------
// array_binary_search_tree
// Binary search tree in implicit heap order, held in one on-chip RAM.
// ----------------------------------------------------------------------------
// Each beat on the slave side carries a command (insert, search or delete)
// and a signed key; one status beat comes back for each. Slot 1 is the root
// and slot n has children 2n and 2n+1; every slot is one RAM word holding a
// valid bit and the key. After reset the block sweeps the RAM to clear all
// valid bits, one slot per cycle, before the first beat is accepted. The
// control walks the tree with one RAM read per cycle. A delete then checks
// the children of each slot it refills or clears and follows the successor
// or predecessor path one level at a time, pulling keys up the tree level by
// level. One item is processed at a time; a new beat is taken as soon as
// the previous result sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module array_binary_search_tree (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // cmd [1:0], key [33:2], zero [39:34]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata    // status [1:0], zero [7:2]
);

    localparam abst_pkg::idx_t ROOT = abst_pkg::IDX_W'(1);

    abst_pkg::state_t  state_reg, state_next;
    logic [abst_pkg::SLOT_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    abst_pkg::status_t m_status_reg, m_status_next;

    abst_pkg::key_t    key_reg, key_next;
    logic [1:0]        cmd_reg, cmd_next;
    abst_pkg::idx_t    slot_reg, slot_next;
    abst_pkg::idx_t    j_reg, j_next;
    abst_pkg::key_t    jkey_reg, jkey_next;
    logic              dir_left_reg, dir_left_next;
    logic              pend_wr_reg, pend_wr_next;
    logic              pend_valid_reg, pend_valid_next;
    abst_pkg::status_t pend_status_reg, pend_status_next;
    logic              inrange_reg;

    logic                         rd_en;
    abst_pkg::idx_t               rd_idx;
    logic [abst_pkg::WORD_W-1:0]  rd_data;
    logic                         wr_en;
    logic [abst_pkg::SLOT_W-1:0]  wr_addr;
    logic [abst_pkg::WORD_W-1:0]  wr_data;

    logic           occ;
    abst_pkg::key_t rkey;
    logic           out_free;
    abst_pkg::idx_t walk_child;
    abst_pkg::idx_t probe;

    abst_ram #(
        .DEPTH (abst_pkg::SLOTS),
        .WIDTH (abst_pkg::WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx[abst_pkg::SLOT_W-1:0]),
        .rd_data (rd_data)
    );

    assign occ      = inrange_reg & rd_data[abst_pkg::KEY_BITS];
    assign rkey     = $signed(rd_data[abst_pkg::KEY_BITS-1:0]);
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == abst_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= abst_pkg::S_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg    <= m_status_next;
        key_reg         <= key_next;
        cmd_reg         <= cmd_next;
        slot_reg        <= slot_next;
        j_reg           <= j_next;
        jkey_reg        <= jkey_next;
        dir_left_reg    <= dir_left_next;
        pend_wr_reg     <= pend_wr_next;
        pend_valid_reg  <= pend_valid_next;
        pend_status_reg <= pend_status_next;
        if (rd_en) begin
            inrange_reg <= (rd_idx < abst_pkg::IDX_W'(abst_pkg::SLOTS));
        end
    end

    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_status_next    = m_status_reg;
        key_next         = key_reg;
        cmd_next         = cmd_reg;
        slot_next        = slot_reg;
        j_next           = j_reg;
        jkey_next        = jkey_reg;
        dir_left_next    = dir_left_reg;
        pend_wr_next     = pend_wr_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        rd_en            = 1'b0;
        rd_idx           = '0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;
        walk_child       = (key_reg < rkey) ? abst_pkg::child_lo(slot_reg)
                                            : abst_pkg::child_hi(slot_reg);
        probe            = dir_left_reg ? abst_pkg::child_lo(j_reg)
                                        : abst_pkg::child_hi(j_reg);

        case (state_reg)
            abst_pkg::S_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == abst_pkg::SLOT_W'(abst_pkg::SLOTS - 1)) begin
                    state_next = abst_pkg::S_IDLE;
                end
            end
            abst_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tdata[1:0];
                    key_next   = abst_pkg::key_of(s_tdata[33:2]);
                    slot_next  = ROOT;
                    rd_en      = 1'b1;
                    rd_idx     = ROOT;
                    state_next = abst_pkg::S_WCHK;
                end
            end
            abst_pkg::S_WCHK: begin
                if (occ && rkey != key_reg) begin
                    slot_next = walk_child;
                    rd_en     = 1'b1;
                    rd_idx    = walk_child;
                end else begin
                    pend_wr_next     = 1'b0;
                    pend_status_next = abst_pkg::STAT_MISS;
                    state_next       = abst_pkg::S_FINISH;
                    case (cmd_reg)
                        abst_pkg::CMD_INSERT: begin
                            if (!occ) begin
                                if (slot_reg < abst_pkg::IDX_W'(abst_pkg::SLOTS)) begin
                                    pend_wr_next     = 1'b1;
                                    pend_valid_next  = 1'b1;
                                    pend_status_next = abst_pkg::STAT_OK;
                                end else begin
                                    pend_status_next = abst_pkg::STAT_FULL;
                                end
                            end
                        end
                        abst_pkg::CMD_SEARCH: begin
                            if (occ) begin
                                pend_status_next = abst_pkg::STAT_OK;
                            end
                        end
                        abst_pkg::CMD_DELETE: begin
                            if (occ) begin
                                pend_status_next = abst_pkg::STAT_OK;
                                rd_en            = 1'b1;
                                rd_idx           = abst_pkg::child_hi(slot_reg);
                                state_next       = abst_pkg::S_RCHK;
                            end
                        end
                        default: begin
                            pend_status_next = abst_pkg::STAT_MISS;
                        end
                    endcase
                end
            end
            abst_pkg::S_RCHK: begin
                rd_en = 1'b1;
                if (occ) begin
                    j_next        = abst_pkg::child_hi(slot_reg);
                    jkey_next     = rkey;
                    dir_left_next = 1'b1;
                    rd_idx        = abst_pkg::child_lo(abst_pkg::child_hi(slot_reg));
                    state_next    = abst_pkg::S_DESC;
                end else begin
                    rd_idx     = abst_pkg::child_lo(slot_reg);
                    state_next = abst_pkg::S_LCHK;
                end
            end
            abst_pkg::S_LCHK: begin
                if (occ) begin
                    j_next        = abst_pkg::child_lo(slot_reg);
                    jkey_next     = rkey;
                    dir_left_next = 1'b0;
                    rd_en         = 1'b1;
                    rd_idx        = abst_pkg::child_hi(abst_pkg::child_lo(slot_reg));
                    state_next    = abst_pkg::S_DESC;
                end else begin
                    pend_wr_next     = 1'b1;
                    pend_valid_next  = 1'b0;
                    pend_status_next = abst_pkg::STAT_OK;
                    state_next       = abst_pkg::S_FINISH;
                end
            end
            abst_pkg::S_DESC: begin
                rd_en = 1'b1;
                if (occ) begin
                    j_next    = probe;
                    jkey_next = rkey;
                    rd_idx    = dir_left_reg ? abst_pkg::child_lo(probe)
                                             : abst_pkg::child_hi(probe);
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = slot_reg[abst_pkg::SLOT_W-1:0];
                    wr_data    = {1'b1, jkey_reg};
                    slot_next  = j_reg;
                    rd_idx     = abst_pkg::child_hi(j_reg);
                    state_next = abst_pkg::S_RCHK;
                end
            end
            abst_pkg::S_FINISH: begin
                if (out_free) begin
                    wr_en         = pend_wr_reg;
                    wr_addr       = slot_reg[abst_pkg::SLOT_W-1:0];
                    wr_data       = {pend_valid_reg, key_reg};
                    m_tvalid_next = 1'b1;
                    m_status_next = pend_status_reg;
                    state_next    = abst_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = abst_pkg::S_IDLE;
            end
        endcase
    end

    // An in-range read of a child must never hit the slot being written in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en && rd_idx < abst_pkg::IDX_W'(abst_pkg::SLOTS))
        |-> (rd_idx[abst_pkg::SLOT_W-1:0] != wr_addr))
        else $error("read and write collide on one slot");

    // While a key is being removed, the slot being refilled is inside the RAM.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == abst_pkg::S_RCHK || state_reg == abst_pkg::S_LCHK ||
         state_reg == abst_pkg::S_DESC)
        |-> (slot_reg < abst_pkg::IDX_W'(abst_pkg::SLOTS)))
        else $error("delete path left the slot range");

    // A finishing item with a free output register presents its status on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == abst_pkg::S_FINISH && out_free) |=> m_tvalid)
        else $error("finished item produced no result beat");

    // An accepted beat starts the walk at the root.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == abst_pkg::S_WCHK && slot_reg == ROOT))
        else $error("accepted beat did not start at the root");

    // No beat is taken and no result beat is offered while the clearing sweep runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == abst_pkg::S_CLEAR) |-> (!s_tready && !m_tvalid))
        else $error("handshake active during the clearing sweep");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the array binary search tree.
// ----------------------------------------------------------------------------
// Command beats (insert, search, delete and the spare code) go in on the
// slave side. A scoreboard keeps its own copy of the implicit-array tree and
// works out the status that each accepted beat should return. Every status
// beat is then checked in order against that copy. A short directed run
// covers the empty tree, duplicates, the full right spine, and deletes along
// successor paths. It is followed by random phases that mix key pools, with
// ascending and descending runs that push the tree past its capacity. Both
// sides stall in random bursts, save one side in two phases and both in the last.
// ----------------------------------------------------------------------------

module testbench;

    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam int         QUIET_MAX  = 4000;
    localparam int         POOL_SIZE  = 48;
    localparam int         PHASE_SIZE = 100;

    class tree_scoreboard;
        abst_pkg::key_t    slot_key[abst_pkg::SLOTS];
        bit                slot_used[abst_pkg::SLOTS];
        abst_pkg::status_t status_due[$];
        int                errors;

        function bit occupied(int unsigned s);
            return s < abst_pkg::SLOTS && slot_used[s];
        endfunction

        function int unsigned find_slot(abst_pkg::key_t k, output bit hit);
            int unsigned s;
            s   = 1;
            hit = 1'b0;
            while (occupied(s)) begin
                if (slot_key[s] == k) begin
                    hit = 1'b1;
                    return s;
                end
                s = (k < slot_key[s]) ? 2 * s : 2 * s + 1;
            end
            return s;
        endfunction

        function void vacate(int unsigned s);
            int unsigned j;
            while (occupied(2 * s) || occupied(2 * s + 1)) begin
                if (occupied(2 * s + 1)) begin
                    j = 2 * s + 1;
                    while (occupied(2 * j)) j = 2 * j;
                end else begin
                    j = 2 * s;
                    while (occupied(2 * j + 1)) j = 2 * j + 1;
                end
                slot_key[s] = slot_key[j];
                s = j;
            end
            if (s < abst_pkg::SLOTS) slot_used[s] = 1'b0;
        endfunction

        function void note_command(logic [1:0] cmd, abst_pkg::key_t k);
            bit                hit;
            int unsigned       s;
            abst_pkg::status_t st;
            s  = find_slot(k, hit);
            st = abst_pkg::STAT_MISS;
            if (cmd == abst_pkg::CMD_INSERT) begin
                if (hit) begin
                    st = abst_pkg::STAT_MISS;
                end else if (s >= abst_pkg::SLOTS) begin
                    st = abst_pkg::STAT_FULL;
                end else begin
                    slot_key[s]  = k;
                    slot_used[s] = 1'b1;
                    st = abst_pkg::STAT_OK;
                end
            end else if (cmd == abst_pkg::CMD_SEARCH) begin
                st = hit ? abst_pkg::STAT_OK : abst_pkg::STAT_MISS;
            end else if (cmd == abst_pkg::CMD_DELETE) begin
                if (hit) begin
                    vacate(s);
                    st = abst_pkg::STAT_OK;
                end
            end
            status_due.push_back(st);
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_status(logic [1:0] got);
            abst_pkg::status_t want;
            if (status_due.size() == 0) begin
                report_mismatch($sformatf("status %0d with no command pending", got));
            end else begin
                want = status_due.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("status %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    tree_scoreboard scoreboard = new();
    abst_pkg::key_t key_pool[POOL_SIZE];
    int             gap_pct   = 0;
    int             stall_pct = 0;
    int             quiet_cycles = 0;

    array_binary_search_tree uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                scoreboard.note_command(s_tdata[1:0], abst_pkg::key_t'(s_tdata[33:2]));
            if (m_tvalid && m_tready)
                scoreboard.check_status(m_tdata[1:0]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_MAX) begin
                    $display("testbench: errors");
                    $finish;
                end
            end
        end
    end

    initial begin
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    task automatic send_command(input logic [1:0] cmd, input abst_pkg::key_t k);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, k, cmd};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic fill_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            case ($urandom_range(3))
                0, 1:    key_pool[i] = abst_pkg::key_t'($signed($urandom_range(200)) - 100);
                2:       key_pool[i] = abst_pkg::key_t'($urandom);
                default: key_pool[i] = abst_pkg::key_t'($urandom_range(1, 4)) << 29;
            endcase
        end
        key_pool[0] = {1'b0, {(abst_pkg::KEY_BITS - 1){1'b1}}};
        key_pool[1] = {1'b1, {(abst_pkg::KEY_BITS - 1){1'b0}}};
    endtask

    task automatic run_random(input int count);
        int             sent;
        int unsigned    roll;
        abst_pkg::key_t base;
        abst_pkg::key_t stride;
        sent = 0;
        fill_pool();
        while (sent < count) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                base   = abst_pkg::key_t'($urandom);
                stride = abst_pkg::key_t'($urandom_range(1, 1000));
                if ($urandom_range(1)) stride = -stride;
                for (int i = 0; i < 12; i++)
                    send_command(abst_pkg::CMD_INSERT, base + stride * i);
                sent += 12;
            end else if (roll < 9) begin
                send_command(CMD_SPARE, abst_pkg::key_t'($urandom));
            end else begin
                roll = $urandom_range(99);
                base = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                                 : abst_pkg::key_t'($urandom);
                if (roll < 42)      send_command(abst_pkg::CMD_INSERT, base);
                else if (roll < 68) send_command(abst_pkg::CMD_SEARCH, base);
                else                send_command(abst_pkg::CMD_DELETE, base);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        gap_pct   = 20;
        stall_pct = 6;
        send_command(abst_pkg::CMD_SEARCH, 5);
        send_command(abst_pkg::CMD_DELETE, 5);
        for (int i = 0; i < 10; i++)
            send_command(abst_pkg::CMD_INSERT, abst_pkg::key_t'(100 + i));
        send_command(abst_pkg::CMD_INSERT, 110);
        send_command(abst_pkg::CMD_SEARCH, 109);
        send_command(abst_pkg::CMD_SEARCH, 110);
        send_command(abst_pkg::CMD_DELETE, 110);
        send_command(abst_pkg::CMD_DELETE, 100);
        send_command(abst_pkg::CMD_INSERT, 110);
        send_command(abst_pkg::CMD_INSERT, 101);
        send_command(abst_pkg::CMD_INSERT, {1'b0, {(abst_pkg::KEY_BITS - 1){1'b1}}});
        send_command(abst_pkg::CMD_INSERT, {1'b1, {(abst_pkg::KEY_BITS - 1){1'b0}}});
        send_command(abst_pkg::CMD_INSERT, -1);
        send_command(abst_pkg::CMD_INSERT, -7);
        send_command(abst_pkg::CMD_DELETE, 101);
        send_command(abst_pkg::CMD_DELETE, {1'b1, {(abst_pkg::KEY_BITS - 1){1'b0}}});
        send_command(CMD_SPARE, 0);
        send_command(abst_pkg::CMD_SEARCH, -7);
        send_command(abst_pkg::CMD_DELETE, {1'b0, {(abst_pkg::KEY_BITS - 1){1'b1}}});
        send_command(abst_pkg::CMD_DELETE, -1);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       begin gap_pct = 30; stall_pct = 10; end
                1:       begin gap_pct = 0;  stall_pct = 8;  end
                2:       begin gap_pct = 25; stall_pct = 0;  end
                3:       begin gap_pct = 10; stall_pct = 4;  end
                4:       begin gap_pct = 40; stall_pct = 15; end
                default: begin gap_pct = 0;  stall_pct = 0;  end
            endcase
            run_random(PHASE_SIZE);
        end

        s_tvalid <= 1'b0;
        while (scoreboard.status_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (scoreboard.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
